/* rtl/core/gms_pkg.sv */
// ----------------------------------------------------------------------------
// gms_pkg
// Shared types, codes and small lookup functions for the gaze motion sequencer.
// ----------------------------------------------------------------------------
package gms_pkg;

	localparam int TIME_W  = 64;
	localparam int HOLD_W  = 32;
	localparam int DIR_W   = 4;
	localparam int FOC_W   = 7;
	localparam int BYTE_W  = 8;
	localparam int ID_W    = 16;
	localparam int PHASE_W = 3;
	localparam int SAC_W   = 7;

	// serial divider sizing: quotient never exceeds the focus range
	localparam int DIV_QW = FOC_W;
	localparam int DIV_DW = SAC_W;
	localparam int DIV_NW = DIV_QW + DIV_DW;

	// request codes
	localparam logic [1:0] REQ_SET   = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// motion phases
	localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SACCADE   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_OVERSHOOT = 3'd2;
	localparam logic [PHASE_W-1:0] PH_SETTLE    = 3'd3;
	localparam logic [PHASE_W-1:0] PH_FIXATION  = 3'd4;

	// direction codes
	localparam logic [DIR_W-1:0] DIR_CENTER    = 4'd0;
	localparam logic [DIR_W-1:0] DIR_LEFT      = 4'd1;
	localparam logic [DIR_W-1:0] DIR_RIGHT     = 4'd2;
	localparam logic [DIR_W-1:0] DIR_UP        = 4'd3;
	localparam logic [DIR_W-1:0] DIR_DOWN      = 4'd4;
	localparam logic [DIR_W-1:0] DIR_UPLEFT    = 4'd5;
	localparam logic [DIR_W-1:0] DIR_UPRIGHT   = 4'd6;
	localparam logic [DIR_W-1:0] DIR_DOWNLEFT  = 4'd7;
	localparam logic [DIR_W-1:0] DIR_DOWNRIGHT = 4'd8;

	// timing in ms
	localparam logic [SAC_W-1:0] SAC_NEAR_MS  = 7'd60;
	localparam logic [SAC_W-1:0] SAC_MID_MS   = 7'd90;
	localparam logic [SAC_W-1:0] SAC_FAR_MS   = 7'd120;
	localparam logic [SAC_W-1:0] OVERSHOOT_MS = 7'd45;
	localparam logic [SAC_W-1:0] SETTLE_MS    = 7'd70;

	// focus shaping
	localparam logic [BYTE_W-1:0] FOCUS_MAX   = 8'd100;
	localparam logic [BYTE_W-1:0] FOCUS_BOOST = 8'd14;
	localparam logic [BYTE_W-1:0] FOCUS_FLOOR = 8'd4;
	// divide by 6 as multiply by 171 and shift by 10, exact over the focus range
	localparam logic [14:0]       DIV6_RECIP  = 15'd171;
	localparam int                DIV6_SHIFT  = 10;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [TIME_W-1:0]  now_ms;
		logic [DIR_W-1:0]   target_direction;
		logic [BYTE_W-1:0]  target_focus;
		logic [BYTE_W-1:0]  target_anchor;
		logic [HOLD_W-1:0]  hold_ms;
		logic               render_valid;
		logic               layer_is_gaze_owner;
		logic [ID_W-1:0]    layer_owner_id;
		logic [BYTE_W-1:0]  shown_anchor;
		logic [DIR_W-1:0]   shown_direction;
		logic [FOC_W-1:0]   shown_focus;
	} gms_req_t;

	typedef struct packed {
		logic               ok;
		logic               write_eyes;
		logic [BYTE_W-1:0]  eye_anchor;
		logic [DIR_W-1:0]   eye_direction;
		logic [FOC_W-1:0]   eye_focus;
		logic [PHASE_W-1:0] motion_phase;
	} gms_rsp_t;

	function automatic logic [FOC_W-1:0] clamp100(input logic [BYTE_W-1:0] v);
		return (v > FOCUS_MAX) ? FOC_W'(FOCUS_MAX) : FOC_W'(v);
	endfunction

	function automatic logic signed [2:0] dir_x(input logic [DIR_W-1:0] d);
		logic signed [2:0] r;
		r = 3'sd0;
		unique case (d)
			DIR_LEFT, DIR_UPLEFT, DIR_DOWNLEFT:    r = -3'sd1;
			DIR_RIGHT, DIR_UPRIGHT, DIR_DOWNRIGHT: r = 3'sd1;
			default:                               r = 3'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [2:0] dir_y(input logic [DIR_W-1:0] d);
		logic signed [2:0] r;
		r = 3'sd0;
		unique case (d)
			DIR_UP, DIR_UPLEFT, DIR_UPRIGHT:       r = -3'sd1;
			DIR_DOWN, DIR_DOWNLEFT, DIR_DOWNRIGHT: r = 3'sd1;
			default:                               r = 3'sd0;
		endcase
		return r;
	endfunction

	function automatic logic [DIR_W-1:0] over_dir(input logic [DIR_W-1:0] d);
		logic [DIR_W-1:0] r;
		r = DIR_CENTER;
		unique case (d)
			DIR_LEFT:                 r = DIR_UPLEFT;
			DIR_RIGHT, DIR_UP:        r = DIR_UPRIGHT;
			DIR_DOWN:                 r = DIR_DOWNRIGHT;
			DIR_UPLEFT, DIR_DOWNLEFT: r = DIR_LEFT;
			DIR_UPRIGHT, DIR_DOWNRIGHT: r = DIR_RIGHT;
			default:                  r = DIR_CENTER;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] manhattan(input logic [DIR_W-1:0] a,
		input logic [DIR_W-1:0] b);
		logic signed [2:0] dx;
		logic signed [2:0] dy;
		logic [2:0]        ax;
		logic [2:0]        ay;
		dx = dir_x(a) - dir_x(b);
		dy = dir_y(a) - dir_y(b);
		ax = dx[2] ? 3'(-dx) : 3'(dx);
		ay = dy[2] ? 3'(-dy) : 3'(dy);
		return ax + ay;
	endfunction

	function automatic logic [4:0] div6(input logic [FOC_W-1:0] g);
		logic [14:0] p;
		p = 15'(g) * DIV6_RECIP;
		return 5'(p >> DIV6_SHIFT);
	endfunction

endpackage

/* rtl/core/gms_ifs.sv */
// ----------------------------------------------------------------------------
// gms_ifs
// Valid/ready channels of the gaze motion sequencer: request, response, config.
// ----------------------------------------------------------------------------
interface gms_req_if import gms_pkg::*; ();
	logic     valid;
	logic     ready;
	gms_req_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface gms_rsp_if import gms_pkg::*; ();
	logic     valid;
	logic     ready;
	gms_rsp_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface gms_cfg_if import gms_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/core/gms_alu.sv */
// ----------------------------------------------------------------------------
// gms_alu
// Shared 64-bit add/subtract unit; carry out doubles as the a >= b flag.
// ----------------------------------------------------------------------------
module gms_alu import gms_pkg::*; (
	input  logic [TIME_W-1:0] a,
	input  logic [TIME_W-1:0] b,
	input  logic              sub,
	output logic [TIME_W-1:0] sum,
	output logic              carry
);

	logic [TIME_W-1:0] b_eff;

	assign b_eff = sub ? ~b : b;
	assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + (TIME_W + 1)'(sub);

endmodule

/* rtl/core/gms_div.sv */
// ----------------------------------------------------------------------------
// gms_div
// Restoring serial divider, one quotient bit per cycle; quotient fits DIV_QW.
// ----------------------------------------------------------------------------
module gms_div import gms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output logic              done,
	output logic [DIV_QW-1:0] quotient
);

	localparam int SW = DIV_DW + DIV_QW - 1;
	localparam int CW = (DIV_QW > 1) ? $clog2(DIV_QW) : 1;

	logic [DIV_NW-1:0] rem_q;
	logic [SW-1:0]     dvs_q;
	logic [DIV_QW-1:0] quo_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_NW-1:0] dvs_ext;
	logic              ge;

	assign dvs_ext  = DIV_NW'(dvs_q);
	assign ge       = rem_q >= dvs_ext;
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= dividend;
				dvs_q  <= SW'(divisor) << (DIV_QW - 1);
				quo_q  <= '0;
				cnt_q  <= CW'(DIV_QW - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ge) begin
					rem_q <= rem_q - dvs_ext;
				end
				quo_q <= {quo_q[DIV_QW-2:0], ge};
				dvs_q <= dvs_q >> 1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/core/gaze_motion_sequencer_top.sv */
// ----------------------------------------------------------------------------
// gaze_motion_sequencer_top
// Eye-gaze motion sequencer: plans saccade/overshoot/settle/fixation timelines
// and steps them on ticks, interpolating focus through a serial divider.
// ----------------------------------------------------------------------------
// set requests step the adder through the four timeline ends; clear and ignored
// requests go straight to the response; req.ready rises in the same cycle as response valid
// tick cost is set by the shared 64-bit adder (one compare or sum per cycle)
// plus the serial divider when focus is interpolated
// a response can wait in the output register while the next request is taken
// arst_n clears all timeline state to idle, owner id to zero
module gaze_motion_sequencer_top import gms_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	gms_cfg_if.sink   cfg,
	gms_req_if.sink   req,
	gms_rsp_if.source rsp
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE,
		S_SET_SAC, S_SET_OVR, S_SET_STL, S_SET_FIX,
		S_T_FIX, S_T_SAC, S_T_OVR, S_T_STL,
		S_I_ELAP, S_I_DUR, S_I_CMP, S_I_DIV,
		S_CMP, S_DONE
	} state_t;

	state_t               state_q;
	gms_req_t             in_q;
	logic [ID_W-1:0]      owner_q;
	logic                 active_q;
	logic [PHASE_W-1:0]   phase_q;
	logic [DIR_W-1:0]     goal_dir_q;
	logic [FOC_W-1:0]     goal_focus_q;
	logic [BYTE_W-1:0]    goal_anchor_q;
	logic [DIR_W-1:0]     over_dir_q;
	logic [DIR_W-1:0]     present_dir_q;
	logic [TIME_W-1:0]    sac_start_q;
	logic [TIME_W-1:0]    sac_end_q;
	logic [TIME_W-1:0]    over_end_q;
	logic [TIME_W-1:0]    settle_end_q;
	logic [TIME_W-1:0]    fix_end_q;
	logic [SAC_W-1:0]     sac_len_q;
	logic                 allow_q;
	logic                 still_q;
	logic                 in_settle_q;
	logic [FOC_W-1:0]     from_q;
	logic [TIME_W-1:0]    elap_q;
	logic [TIME_W-1:0]    dur_q;
	logic [DIR_W-1:0]     dir_q;
	logic [FOC_W-1:0]     foc_q;
	logic                 ok_q;
	logic                 wr_q;
	logic                 rsp_valid_q;
	gms_rsp_t             rsp_q;

	logic [TIME_W-1:0]    alu_a;
	logic [TIME_W-1:0]    alu_b;
	logic                 alu_sub;
	logic [TIME_W-1:0]    alu_sum;
	logic                 alu_carry;

	logic [2:0]           move_dist;
	logic                 diag;
	logic                 can_write;
	logic [TIME_W-1:0]    interp_base;
	logic [TIME_W-1:0]    interp_end;
	logic                 from_above;
	logic [FOC_W-1:0]     mag;
	logic                 div_start;
	logic [DIV_NW-1:0]    div_num;
	logic                 div_done;
	logic [DIV_QW-1:0]    div_quo;
	logic [BYTE_W-1:0]    interp_foc;
	logic [FOC_W-1:0]     boosted;

	gms_alu u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.sub   (alu_sub),
		.sum   (alu_sum),
		.carry (alu_carry)
	);

	gms_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (dur_q[DIV_DW-1:0]),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign req.ready   = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	assign move_dist = manhattan(present_dir_q, in_q.target_direction);
	assign diag      = (dir_x(in_q.target_direction) != 3'sd0) &&
		(dir_y(in_q.target_direction) != 3'sd0);
	assign can_write = (owner_q != '0) && in_q.layer_is_gaze_owner &&
		(in_q.layer_owner_id == owner_q);
	assign boosted   = clamp100(BYTE_W'(goal_focus_q) + FOCUS_BOOST);

	assign interp_base = in_settle_q ? over_end_q : sac_start_q;
	assign interp_end  = in_settle_q ? settle_end_q : sac_end_q;
	assign from_above  = from_q > goal_focus_q;
	assign mag         = from_above ? (from_q - goal_focus_q) : (goal_focus_q - from_q);
	assign div_num     = DIV_NW'(mag) * DIV_NW'(elap_q[SAC_W-1:0]);
	// early exit when the span is empty or already elapsed
	assign div_start   = (state_q == S_I_CMP) && (dur_q != '0) && !alu_carry;
	assign interp_foc  = from_above ? (BYTE_W'(from_q) - BYTE_W'(div_quo)) :
		(BYTE_W'(from_q) + BYTE_W'(div_quo));

	// operand select for the shared adder
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			S_SET_SAC: begin
				alu_a = in_q.now_ms;
				alu_b = TIME_W'(sac_len_q);
			end
			S_SET_OVR: begin
				alu_a = sac_end_q;
				alu_b = allow_q ? TIME_W'(OVERSHOOT_MS) : '0;
			end
			S_SET_STL: begin
				alu_a = over_end_q;
				alu_b = allow_q ? TIME_W'(SETTLE_MS) : '0;
			end
			S_SET_FIX: begin
				alu_a = settle_end_q;
				alu_b = TIME_W'(in_q.hold_ms);
			end
			S_T_FIX: begin
				alu_a   = fix_end_q;
				alu_b   = in_q.now_ms;
				alu_sub = 1'b1;
			end
			S_T_SAC: begin
				alu_a   = in_q.now_ms;
				alu_b   = sac_end_q;
				alu_sub = 1'b1;
			end
			S_T_OVR: begin
				alu_a   = in_q.now_ms;
				alu_b   = over_end_q;
				alu_sub = 1'b1;
			end
			S_T_STL: begin
				alu_a   = in_q.now_ms;
				alu_b   = settle_end_q;
				alu_sub = 1'b1;
			end
			S_I_ELAP: begin
				alu_a   = in_q.now_ms;
				alu_b   = interp_base;
				alu_sub = 1'b1;
			end
			S_I_DUR: begin
				alu_a   = interp_end;
				alu_b   = interp_base;
				alu_sub = 1'b1;
			end
			S_I_CMP: begin
				alu_a   = elap_q;
				alu_b   = dur_q;
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			in_q          <= '0;
			owner_q       <= '0;
			active_q      <= 1'b0;
			phase_q       <= PH_IDLE;
			goal_dir_q    <= DIR_CENTER;
			goal_focus_q  <= '0;
			goal_anchor_q <= '0;
			over_dir_q    <= DIR_CENTER;
			present_dir_q <= DIR_CENTER;
			sac_start_q   <= '0;
			sac_end_q     <= '0;
			over_end_q    <= '0;
			settle_end_q  <= '0;
			fix_end_q     <= '0;
			sac_len_q     <= '0;
			allow_q       <= 1'b0;
			still_q       <= 1'b0;
			in_settle_q   <= 1'b0;
			from_q        <= '0;
			elap_q        <= '0;
			dur_q         <= '0;
			dir_q         <= DIR_CENTER;
			foc_q         <= '0;
			ok_q          <= 1'b0;
			wr_q          <= 1'b0;
			rsp_valid_q   <= 1'b0;
			rsp_q         <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				owner_q <= cfg.data;
			end
			// S_DONE handles the output register itself
			if (rsp_valid_q && rsp.ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						in_q    <= req.payload;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					ok_q  <= 1'b0;
					wr_q  <= 1'b0;
					dir_q <= goal_dir_q;
					foc_q <= goal_focus_q;
					unique case (in_q.req_type)
						REQ_SET: begin
							if (in_q.hold_ms != '0) begin
								goal_dir_q    <= in_q.target_direction;
								goal_focus_q  <= clamp100(in_q.target_focus);
								goal_anchor_q <= in_q.target_anchor;
								over_dir_q    <= over_dir(in_q.target_direction);
								sac_len_q     <= (move_dist <= 3'd1) ? SAC_NEAR_MS :
									((move_dist == 3'd2) ? SAC_MID_MS : SAC_FAR_MS);
								allow_q       <= (move_dist != 3'd0) && !diag;
								still_q       <= (move_dist == 3'd0);
								sac_start_q   <= in_q.now_ms;
								state_q       <= S_SET_SAC;
							end else begin
								state_q <= S_DONE;
							end
						end
						REQ_CLEAR: begin
							active_q     <= 1'b0;
							phase_q      <= PH_IDLE;
							sac_start_q  <= '0;
							sac_end_q    <= '0;
							over_end_q   <= '0;
							settle_end_q <= '0;
							fix_end_q    <= '0;
							state_q      <= S_DONE;
						end
						REQ_TICK: begin
							if (in_q.render_valid && can_write && active_q) begin
								state_q <= S_T_FIX;
							end else begin
								state_q <= S_DONE;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_SET_SAC: begin
					sac_end_q <= alu_sum;
					state_q   <= S_SET_OVR;
				end
				S_SET_OVR: begin
					over_end_q <= alu_sum;
					state_q    <= S_SET_STL;
				end
				S_SET_STL: begin
					settle_end_q <= alu_sum;
					state_q      <= S_SET_FIX;
				end
				S_SET_FIX: begin
					fix_end_q <= alu_sum;
					phase_q   <= still_q ? PH_FIXATION : PH_SACCADE;
					active_q  <= 1'b1;
					ok_q      <= 1'b1;
					state_q   <= S_DONE;
				end
				S_T_FIX: begin
					// no carry means now is past the end of fixation
					if (!alu_carry) begin
						active_q <= 1'b0;
						phase_q  <= PH_IDLE;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_T_SAC;
					end
				end
				S_T_SAC: begin
					if (!alu_carry) begin
						phase_q     <= PH_SACCADE;
						from_q      <= clamp100(BYTE_W'(div6(goal_focus_q)) + FOCUS_FLOOR);
						in_settle_q <= 1'b0;
						state_q     <= S_I_ELAP;
					end else begin
						state_q <= S_T_OVR;
					end
				end
				S_T_OVR: begin
					if (!alu_carry) begin
						phase_q <= PH_OVERSHOOT;
						dir_q   <= over_dir_q;
						foc_q   <= boosted;
						state_q <= S_CMP;
					end else begin
						state_q <= S_T_STL;
					end
				end
				S_T_STL: begin
					if (!alu_carry) begin
						phase_q     <= PH_SETTLE;
						from_q      <= boosted;
						in_settle_q <= 1'b1;
						state_q     <= S_I_ELAP;
					end else begin
						phase_q <= PH_FIXATION;
						state_q <= S_CMP;
					end
				end
				S_I_ELAP: begin
					elap_q  <= alu_sum;
					state_q <= S_I_DUR;
				end
				S_I_DUR: begin
					dur_q   <= alu_sum;
					state_q <= S_I_CMP;
				end
				S_I_CMP: begin
					if (div_start) begin
						state_q <= S_I_DIV;
					end else begin
						foc_q   <= goal_focus_q;
						state_q <= S_CMP;
					end
				end
				S_I_DIV: begin
					if (div_done) begin
						foc_q   <= clamp100(interp_foc);
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if ((in_q.shown_anchor != goal_anchor_q) ||
						(in_q.shown_direction != dir_q) ||
						(in_q.shown_focus != foc_q)) begin
						ok_q          <= 1'b1;
						wr_q          <= 1'b1;
						present_dir_q <= dir_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_q.ok            <= ok_q;
						rsp_q.write_eyes    <= wr_q;
						rsp_q.eye_anchor    <= wr_q ? goal_anchor_q : '0;
						rsp_q.eye_direction <= wr_q ? dir_q : DIR_CENTER;
						rsp_q.eye_focus     <= wr_q ? foc_q : '0;
						rsp_q.motion_phase  <= phase_q;
						rsp_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_idle_when_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (phase_q == PH_IDLE))
		else $error("inactive sequencer left in a motion phase");

	a_write_implies_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.write_eyes |-> rsp_q.ok)
		else $error("eye write reported without ok");

	a_quiet_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.write_eyes |->
		(rsp_q.eye_anchor == '0) && (rsp_q.eye_direction == '0) && (rsp_q.eye_focus == '0))
		else $error("eye fields nonzero without a write");

	a_focus_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (BYTE_W'(rsp_q.eye_focus) <= FOCUS_MAX))
		else $error("eye focus above range");

	a_div_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (dur_q[TIME_W-1:SAC_W] == '0) && (elap_q < dur_q))
		else $error("interpolation span out of divider range");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gaze motion sequencer. Directed phase walks and
// edge requests come first, then randomized target/tick traffic under several
// owner ids. Every response is compared against an in-bench timeline model.
// ----------------------------------------------------------------------------
module tb_top;
	import gms_pkg::*;

	localparam logic [1:0]        REQ_UNUSED = 2'd3;
	localparam int                FOCUS_DIV  = 6;
	localparam logic [TIME_W-1:0] TIME_TOP   = '1;
	localparam logic [DIR_W-1:0]  DIR_TOP    = '1;

	typedef struct packed {
		logic               active;
		logic [PHASE_W-1:0] phase;
		logic [DIR_W-1:0]   goal_dir;
		logic [FOC_W-1:0]   goal_focus;
		logic [BYTE_W-1:0]  goal_anchor;
		logic [DIR_W-1:0]   detour_dir;
		logic [DIR_W-1:0]   present_dir;
		logic [TIME_W-1:0]  sac_start;
		logic [TIME_W-1:0]  sac_end;
		logic [TIME_W-1:0]  over_end;
		logic [TIME_W-1:0]  settle_end;
		logic [TIME_W-1:0]  fix_end;
	} gaze_plan_t;

	typedef struct packed {
		logic [BYTE_W-1:0] anchor;
		logic [DIR_W-1:0]  dir;
		logic [FOC_W-1:0]  focus;
	} eye_view_t;

	logic clk;
	logic arst_n;

	gms_cfg_if cfg_bus();
	gms_req_if req_bus();
	gms_rsp_if rsp_bus();

	gaze_motion_sequencer_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	gaze_plan_t        plan;
	logic [ID_W-1:0]   owner_shadow;
	eye_view_t         host_eyes;
	gms_rsp_t          pending_rsp[$];
	logic [TIME_W-1:0] clock_ms;
	int unsigned       items_done;
	int unsigned       mismatches;
	bit                idle_on;

	// ---------------------------------------------------------------- model

	function automatic void dir_vector(input logic [DIR_W-1:0] d, output int vx, output int vy);
		vx = 0;
		vy = 0;
		case (d)
			DIR_LEFT:      vx = -1;
			DIR_RIGHT:     vx = 1;
			DIR_UP:        vy = -1;
			DIR_DOWN:      vy = 1;
			DIR_UPLEFT:    begin vx = -1; vy = -1; end
			DIR_UPRIGHT:   begin vx = 1;  vy = -1; end
			DIR_DOWNLEFT:  begin vx = -1; vy = 1;  end
			DIR_DOWNRIGHT: begin vx = 1;  vy = 1;  end
			default:       ;
		endcase
	endfunction

	function automatic logic [DIR_W-1:0] detour_for(input logic [DIR_W-1:0] d);
		case (d)
			DIR_LEFT:                   return DIR_UPLEFT;
			DIR_RIGHT, DIR_UP:          return DIR_UPRIGHT;
			DIR_DOWN:                   return DIR_DOWNRIGHT;
			DIR_UPLEFT, DIR_DOWNLEFT:   return DIR_LEFT;
			DIR_UPRIGHT, DIR_DOWNRIGHT: return DIR_RIGHT;
			default:                    return DIR_CENTER;
		endcase
	endfunction

	function automatic logic [FOC_W-1:0] cap_focus(input int unsigned v);
		if (v > FOCUS_MAX)
			return FOC_W'(FOCUS_MAX);
		return FOC_W'(v);
	endfunction

	// linear blend, quotient truncated
	function automatic logic [FOC_W-1:0] ramp_focus(input int unsigned start_f,
		input int unsigned goal_f, input logic [TIME_W-1:0] elapsed,
		input logic [TIME_W-1:0] span);
		logic [TIME_W-1:0] q;
		if (span == '0 || elapsed >= span)
			return FOC_W'(goal_f);
		if (start_f > goal_f) begin
			q = (TIME_W'(start_f - goal_f) * elapsed) / span;
			return cap_focus(start_f - int'(q));
		end
		q = (TIME_W'(goal_f - start_f) * elapsed) / span;
		return cap_focus(start_f + int'(q));
	endfunction

	function automatic gms_rsp_t step_gaze(input gms_req_t r);
		gms_rsp_t          res;
		logic [DIR_W-1:0]  dir;
		logic [FOC_W-1:0]  foc;
		logic [TIME_W-1:0] sac;
		int                px, py, tx, ty, move_dist;
		bit                detour;
		res = '0;
		case (r.req_type)
			REQ_SET: begin
				if (r.hold_ms != '0) begin
					dir_vector(plan.present_dir, px, py);
					dir_vector(r.target_direction, tx, ty);
					move_dist = ((px > tx) ? px - tx : tx - px) +
						((py > ty) ? py - ty : ty - py);
					sac = (move_dist <= 1) ? TIME_W'(SAC_NEAR_MS) :
						((move_dist == 2) ? TIME_W'(SAC_MID_MS) : TIME_W'(SAC_FAR_MS));
					detour = (move_dist != 0) && !(tx != 0 && ty != 0);
					plan.goal_dir    = r.target_direction;
					plan.goal_focus  = cap_focus(r.target_focus);
					plan.goal_anchor = r.target_anchor;
					plan.detour_dir  = detour_for(r.target_direction);
					plan.sac_start   = r.now_ms;
					plan.sac_end     = r.now_ms + sac;
					plan.over_end    = plan.sac_end + (detour ? TIME_W'(OVERSHOOT_MS) : '0);
					plan.settle_end  = plan.over_end + (detour ? TIME_W'(SETTLE_MS) : '0);
					plan.fix_end     = plan.settle_end + TIME_W'(r.hold_ms);
					plan.phase       = (move_dist == 0) ? PH_FIXATION : PH_SACCADE;
					plan.active      = 1'b1;
					res.ok           = 1'b1;
				end
			end
			REQ_CLEAR: begin
				plan.active     = 1'b0;
				plan.phase      = PH_IDLE;
				plan.sac_start  = '0;
				plan.sac_end    = '0;
				plan.over_end   = '0;
				plan.settle_end = '0;
				plan.fix_end    = '0;
			end
			REQ_TICK: begin
				if (r.render_valid && r.layer_is_gaze_owner && owner_shadow != '0 &&
					r.layer_owner_id == owner_shadow && plan.active) begin
					if (r.now_ms > plan.fix_end) begin
						plan.active = 1'b0;
						plan.phase  = PH_IDLE;
					end else begin
						dir = plan.goal_dir;
						foc = plan.goal_focus;
						if (r.now_ms < plan.sac_end) begin
							plan.phase = PH_SACCADE;
							foc = ramp_focus(cap_focus(int'(plan.goal_focus) / FOCUS_DIV +
								int'(FOCUS_FLOOR)), plan.goal_focus,
								r.now_ms - plan.sac_start, plan.sac_end - plan.sac_start);
						end else if (r.now_ms < plan.over_end) begin
							plan.phase = PH_OVERSHOOT;
							dir = plan.detour_dir;
							foc = cap_focus(int'(plan.goal_focus) + int'(FOCUS_BOOST));
						end else if (r.now_ms < plan.settle_end) begin
							plan.phase = PH_SETTLE;
							foc = ramp_focus(cap_focus(int'(plan.goal_focus) + int'(FOCUS_BOOST)),
								plan.goal_focus, r.now_ms - plan.over_end,
								plan.settle_end - plan.over_end);
						end else begin
							plan.phase = PH_FIXATION;
						end
						if (r.shown_anchor != plan.goal_anchor || r.shown_direction != dir ||
							r.shown_focus != foc) begin
							res.ok            = 1'b1;
							res.write_eyes    = 1'b1;
							res.eye_anchor    = plan.goal_anchor;
							res.eye_direction = dir;
							res.eye_focus     = foc;
							plan.present_dir  = dir;
						end
					end
				end
			end
			default: ;
		endcase
		res.motion_phase = plan.phase;
		return res;
	endfunction

	// ---------------------------------------------------------------- items

	function automatic gms_req_t noise_item();
		gms_req_t     r;
		logic [159:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
		r = bits[$bits(gms_req_t)-1:0];
		return r;
	endfunction

	function automatic gms_req_t make_plain(input logic [1:0] kind, input logic [TIME_W-1:0] at);
		gms_req_t r;
		r = noise_item();
		r.req_type = kind;
		r.now_ms   = at;
		return r;
	endfunction

	function automatic gms_req_t make_set(input logic [TIME_W-1:0] at,
		input logic [DIR_W-1:0] dir, input logic [BYTE_W-1:0] focus,
		input logic [BYTE_W-1:0] anchor, input logic [HOLD_W-1:0] hold);
		gms_req_t r;
		r = make_plain(REQ_SET, at);
		r.target_direction = dir;
		r.target_focus     = focus;
		r.target_anchor    = anchor;
		r.hold_ms          = hold;
		return r;
	endfunction

	// tick as a well-behaved host sends it: shown values are what it last stored
	function automatic gms_req_t make_tick(input logic [TIME_W-1:0] at, input bit rv,
		input bit role, input logic [ID_W-1:0] lown);
		gms_req_t r;
		r = make_plain(REQ_TICK, at);
		r.render_valid        = rv;
		r.layer_is_gaze_owner = role;
		r.layer_owner_id      = lown;
		r.shown_anchor        = host_eyes.anchor;
		r.shown_direction     = host_eyes.dir;
		r.shown_focus         = host_eyes.focus;
		return r;
	endfunction

	// ---------------------------------------------------------------- channels

	task automatic send_item(input gms_req_t r, output gms_rsp_t predicted);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			req_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_bus.payload <= r;
		req_bus.valid   <= 1'b1;
		do @(posedge clk); while (!req_bus.ready);
		predicted = step_gaze(r);
		pending_rsp.push_back(predicted);
		if (predicted.write_eyes)
			host_eyes = {predicted.eye_anchor, predicted.eye_direction, predicted.eye_focus};
		if (r.req_type != REQ_UNUSED)
			items_done++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		if (req_bus.valid) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		while (pending_rsp.size() != 0)
			@(negedge clk);
	endtask

	// only called with nothing in flight
	task automatic write_owner(input logic [ID_W-1:0] id);
		cfg_bus.data  <= id;
		cfg_bus.valid <= 1'b1;
		do @(posedge clk); while (!cfg_bus.ready);
		owner_shadow = id;
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	function automatic void check_field(input string field, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endfunction

	// ---------------------------------------------------------------- tests

	// owner id still zero after reset, so no tick may write
	task automatic test_reset_blocking();
		gms_rsp_t seen;
		send_item(make_tick(64'd0, 1'b1, 1'b1, '0), seen);
		send_item(make_set(64'd1000, DIR_RIGHT, 8'd60, 8'hA5, 32'd1), seen);
		send_item(make_tick(64'd1010, 1'b1, 1'b1, '0), seen);
		send_item(make_plain(REQ_UNUSED, 64'd1010), seen);
	endtask

	// the non-diagonal move set in the reset test, walked through every phase
	task automatic test_phase_walk();
		gms_rsp_t seen;
		drain_results();
		write_owner('1);
		send_item(make_tick(64'd995, 1'b1, 1'b1, '1), seen);
		send_item(make_tick(64'd1010, 1'b1, 1'b1, '1), seen);
		send_item(make_tick(64'd1020, 1'b1, 1'b0, '1), seen);
		send_item(make_tick(64'd1020, 1'b0, 1'b1, '1), seen);
		send_item(make_tick(64'd1020, 1'b1, 1'b1, 16'h7FFF), seen);
		send_item(make_tick(64'd1070, 1'b1, 1'b1, '1), seen);
		send_item(make_tick(64'd1140, 1'b1, 1'b1, '1), seen);
		send_item(make_tick(64'd1175, 1'b1, 1'b1, '1), seen);
		send_item(make_tick(64'd1176, 1'b1, 1'b1, '1), seen);
		send_item(make_tick(64'd1177, 1'b1, 1'b1, '1), seen);
	endtask

	task automatic test_edge_requests();
		gms_rsp_t seen;
		send_item(make_set(64'd1200, DIR_UP, 8'd50, 8'd7, '0), seen);
		// diagonal target, longest hold, timeline wraps past zero
		send_item(make_set(TIME_TOP - 63, DIR_DOWNRIGHT, 8'd0, 8'hFF, '1), seen);
		send_item(make_tick(TIME_TOP, 1'b1, 1'b1, '1), seen);
		// undefined direction code behaves as center but is written as given
		send_item(make_set(TIME_TOP - 15, DIR_TOP, 8'hFF, 8'h00, 32'd100), seen);
		send_item(make_tick(64'h20, 1'b1, 1'b1, '1), seen);
		send_item(make_tick(64'h40, 1'b1, 1'b1, '1), seen);
		// same direction as shown: straight to fixation
		send_item(make_set(64'd500, DIR_CENTER, 8'd100, 8'h3C, 32'd5), seen);
		send_item(make_tick(64'd502, 1'b1, 1'b1, '1), seen);
		send_item(make_tick(64'd503, 1'b1, 1'b1, '1), seen);
		send_item(make_plain(REQ_CLEAR, 64'd503), seen);
		send_item(make_plain(REQ_UNUSED, 64'd503), seen);
		send_item(make_tick(64'd504, 1'b1, 1'b1, '1), seen);
	endtask

	// set target, then ticks marching through the timeline
	task automatic play_gaze_move(input logic [ID_W-1:0] id);
		gms_rsp_t          got;
		gms_req_t          r;
		logic [TIME_W-1:0] t0;
		logic [TIME_W-1:0] at;
		logic [HOLD_W-1:0] hold;
		logic [DIR_W-1:0]  dir;
		int                ticks;
		if ($urandom_range(0, 15) == 0)
			clock_ms = TIME_TOP - TIME_W'($urandom_range(0, 400));
		t0 = clock_ms;
		case ($urandom_range(0, 7))
			0:       hold = '0;
			1:       hold = $urandom;
			default: hold = $urandom_range(1, 250);
		endcase
		if ($urandom_range(0, 9) == 0)
			dir = DIR_W'($urandom_range(DIR_DOWNRIGHT + 1, DIR_TOP));
		else
			dir = DIR_W'($urandom_range(DIR_CENTER, DIR_DOWNRIGHT));
		send_item(make_set(t0, dir, BYTE_W'($urandom), BYTE_W'($urandom), hold), got);
		ticks = $urandom_range(2, 30);
		while (ticks > 0) begin
			ticks--;
			if ($urandom_range(0, 15) == 0)
				clock_ms += TIME_W'($urandom_range(100, 2000));
			else
				clock_ms += TIME_W'($urandom_range(1, 25));
			at = ($urandom_range(0, 19) == 0) ? t0 - TIME_W'($urandom_range(1, 40)) :
				clock_ms;
			r = make_tick(at, $urandom_range(0, 15) != 0, $urandom_range(0, 15) != 0,
				($urandom_range(0, 15) == 0) ? ID_W'($urandom) : id);
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 2))
					0:       r.shown_anchor = BYTE_W'($urandom);
					1:       r.shown_direction = DIR_W'($urandom);
					default: r.shown_focus = FOC_W'($urandom);
				endcase
			end
			send_item(r, got);
			if (got.motion_phase == PH_IDLE)
				ticks = 0;
		end
	endtask

	task automatic test_random_traffic();
		gms_rsp_t        got;
		logic [ID_W-1:0] id;
		int unsigned     stop_at;
		int              p;
		for (p = 0; p < 6; p++) begin
			case (p)
				0:       id = '1;
				1:       id = ID_W'(1);
				3:       id = '0;
				default: id = ID_W'($urandom_range(2, 16'hFFFE));
			endcase
			// last stretch runs with no request gaps and the response side always ready
			if (p == 5)
				idle_on = 1'b0;
			drain_results();
			write_owner(id);
			stop_at = items_done + ((id == '0) ? 40 : 122);
			while (items_done < stop_at) begin
				case ($urandom_range(0, 19))
					0, 1:    send_item(make_plain(REQ_CLEAR, clock_ms), got);
					2:       send_item(make_plain(REQ_UNUSED, clock_ms), got);
					3, 4:    send_item(noise_item(), got);
					5:       drain_results();
					default: play_gaze_move(id);
				endcase
			end
		end
	endtask

	// ---------------------------------------------------------------- processes

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	// response side stalls in short bursts
	initial begin
		int n;
		rsp_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 4);
				rsp_bus.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			rsp_bus.ready <= 1'b1;
		end
	end

	initial begin
		gms_rsp_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
				if (pending_rsp.size() == 0) begin
					$error("response transaction with no request outstanding");
					mismatches++;
				end else begin
					want = pending_rsp.pop_front();
					check_field("ok", 64'(want.ok), 64'(rsp_bus.payload.ok));
					check_field("write_eyes", 64'(want.write_eyes),
						64'(rsp_bus.payload.write_eyes));
					check_field("eye_anchor", 64'(want.eye_anchor),
						64'(rsp_bus.payload.eye_anchor));
					check_field("eye_direction", 64'(want.eye_direction),
						64'(rsp_bus.payload.eye_direction));
					check_field("eye_focus", 64'(want.eye_focus),
						64'(rsp_bus.payload.eye_focus));
					check_field("motion_phase", 64'(want.motion_phase),
						64'(rsp_bus.payload.motion_phase));
				end
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		req_bus.valid   = 1'b0;
		req_bus.payload = '0;
		cfg_bus.valid   = 1'b0;
		cfg_bus.data    = '0;
		plan            = '0;
		owner_shadow    = '0;
		host_eyes       = '0;
		clock_ms        = 64'd5000;
		items_done      = 0;
		mismatches      = 0;
		idle_on         = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_blocking();
		test_phase_walk();
		test_edge_requests();
		test_random_traffic();

		drain_results();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

/* files.f */
rtl/core/gms_pkg.sv
rtl/core/gms_ifs.sv
rtl/core/gms_alu.sv
rtl/core/gms_div.sv
rtl/core/gaze_motion_sequencer_top.sv
sim/tb_top.sv
